// File: sv/pipm_pkg.sv
// Shared types and constants for the point-in-polygon margin test.
// Holds the controller states, the command and status structs and the
// multiply-accumulate step table; used by every module of the block.
package pipm_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int MARGIN_BITS = 15;
	localparam int NUM_UOPS = 20;
	localparam int UOP_IDX_BITS = $clog2(NUM_UOPS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OPEN,
		ST_CLOSE,
		ST_RUN,
		ST_DRAIN,
		ST_DECIDE,
		ST_EMIT
	} state_t;

	typedef enum logic [3:0] {
		OP_DX,
		OP_DY,
		OP_DX1,
		OP_DY1,
		OP_EX,
		OP_EY,
		OP_MRG,
		OP_DH,
		OP_DL,
		OP_LH,
		OP_LL,
		OP_RH,
		OP_RL
	} op_sel_t;

	typedef enum logic [1:0] {
		ACC_NONE,
		ACC_START,
		ACC_ADD,
		ACC_SUB
	} acc_mode_t;

	typedef enum logic [1:0] {
		SH_0,
		SH_L,
		SH_L1,
		SH_2L
	} shift_t;

	typedef enum logic [2:0] {
		DST_NONE,
		DST_D,
		DST_LEN,
		DST_RN,
		DST_DA,
		DST_DB,
		DST_RR
	} dest_t;

	typedef struct packed {
		op_sel_t   opa;
		op_sel_t   opb;
		acc_mode_t mode;
		shift_t    shift;
		dest_t     dest;
	} uop_t;

	typedef struct packed {
		logic load;
		logic edge_open;
		logic edge_close;
		uop_t uop;
		logic decide;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} dp_status_t;

	localparam uop_t UOP_NOP = '{OP_DX, OP_DX, ACC_NONE, SH_0, DST_NONE};

	// cross term, squared length, margin squared, projection, end distances,
	// then cross term squared minus margin squared times length in limbs
	localparam uop_t UOP_ROM [NUM_UOPS] = '{
		'{OP_DX,  OP_DY1, ACC_START, SH_0,  DST_NONE},
		'{OP_DY,  OP_DX1, ACC_SUB,   SH_0,  DST_D},
		'{OP_DX,  OP_DX,  ACC_START, SH_0,  DST_NONE},
		'{OP_DY,  OP_DY,  ACC_ADD,   SH_0,  DST_LEN},
		'{OP_MRG, OP_MRG, ACC_START, SH_0,  DST_RR},
		'{OP_DX,  OP_DX1, ACC_START, SH_0,  DST_NONE},
		'{OP_DY,  OP_DY1, ACC_ADD,   SH_0,  DST_RN},
		'{OP_DX1, OP_DX1, ACC_START, SH_0,  DST_NONE},
		'{OP_DY1, OP_DY1, ACC_ADD,   SH_0,  DST_NONE},
		'{OP_MRG, OP_MRG, ACC_SUB,   SH_0,  DST_DA},
		'{OP_EX,  OP_EX,  ACC_START, SH_0,  DST_NONE},
		'{OP_EY,  OP_EY,  ACC_ADD,   SH_0,  DST_NONE},
		'{OP_MRG, OP_MRG, ACC_SUB,   SH_0,  DST_DB},
		'{OP_DL,  OP_DL,  ACC_START, SH_0,  DST_NONE},
		'{OP_DH,  OP_DL,  ACC_ADD,   SH_L1, DST_NONE},
		'{OP_DH,  OP_DH,  ACC_ADD,   SH_2L, DST_NONE},
		'{OP_RL,  OP_LL,  ACC_SUB,   SH_0,  DST_NONE},
		'{OP_RL,  OP_LH,  ACC_SUB,   SH_L,  DST_NONE},
		'{OP_RH,  OP_LL,  ACC_SUB,   SH_L,  DST_NONE},
		'{OP_RH,  OP_LH,  ACC_SUB,   SH_2L, DST_NONE}
	};

endpackage

// File: sv/pipm_ctrl.sv
// Controller of the point-in-polygon margin test: state machine and step
// counter that sequence edge set-up, the shared multiplier and the result.
// Depends on pipm_pkg.
module pipm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  first_vertex,
	input  logic                  last_vertex,
	output logic                  in_stall,
	input  pipm_pkg::dp_status_t  status,
	output pipm_pkg::cmd_t        cmd
);

	pipm_pkg::state_t state_q, state_d;
	logic [pipm_pkg::UOP_IDX_BITS-1:0] step_q;
	logic last_q;
	logic closing_q;
	logic step_end;

	assign step_end = (step_q == pipm_pkg::UOP_IDX_BITS'(pipm_pkg::NUM_UOPS - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pipm_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (!first_vertex) begin
						state_d = pipm_pkg::ST_OPEN;
					end else if (last_vertex) begin
						state_d = pipm_pkg::ST_CLOSE;
					end
				end
			end
			pipm_pkg::ST_OPEN, pipm_pkg::ST_CLOSE: begin
				state_d = pipm_pkg::ST_RUN;
			end
			pipm_pkg::ST_RUN: begin
				if (step_end) begin
					state_d = pipm_pkg::ST_DRAIN;
				end
			end
			pipm_pkg::ST_DRAIN: begin
				state_d = pipm_pkg::ST_DECIDE;
			end
			pipm_pkg::ST_DECIDE: begin
				priority if (last_q && !closing_q) begin
					state_d = pipm_pkg::ST_CLOSE;
				end else if (last_q) begin
					state_d = pipm_pkg::ST_EMIT;
				end else begin
					state_d = pipm_pkg::ST_IDLE;
				end
			end
			pipm_pkg::ST_EMIT: begin
				if (!status.out_busy) begin
					state_d = pipm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pipm_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall = (state_q != pipm_pkg::ST_IDLE);
		cmd.load = (state_q == pipm_pkg::ST_IDLE) && in_valid;
		cmd.edge_open = (state_q == pipm_pkg::ST_OPEN);
		cmd.edge_close = (state_q == pipm_pkg::ST_CLOSE);
		cmd.uop = (state_q == pipm_pkg::ST_RUN) ? pipm_pkg::UOP_ROM[step_q] : pipm_pkg::UOP_NOP;
		cmd.decide = (state_q == pipm_pkg::ST_DECIDE);
		cmd.emit = (state_q == pipm_pkg::ST_EMIT) && !status.out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pipm_pkg::ST_IDLE;
			step_q <= '0;
			last_q <= 1'b0;
			closing_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == pipm_pkg::ST_RUN && !step_end) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
			if (cmd.load) begin
				last_q <= last_vertex;
			end
			if (cmd.edge_open) begin
				closing_q <= 1'b0;
			end else if (cmd.edge_close) begin
				closing_q <= 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != pipm_pkg::ST_RUN |-> step_q == '0)
		else $error("step counter moved outside the multiply run");

	a_emit_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> last_q)
		else $error("result emitted for an item that is not a last vertex");

	a_drain_decide: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pipm_pkg::ST_DRAIN |=> state_q == pipm_pkg::ST_DECIDE)
		else $error("drain not followed by decide");

	a_close_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pipm_pkg::ST_DECIDE && last_q && !closing_q)
		|=> state_q == pipm_pkg::ST_CLOSE)
		else $error("closing edge skipped on a last vertex");
`endif

endmodule

// File: sv/pipm_dp.sv
// Datapath of the point-in-polygon margin test: vertex and query registers,
// edge differences, one shared signed multiplier with a wide accumulator,
// the decision logic and the output register. Depends on pipm_pkg.
module pipm_dp #(
	parameter int COORD_BITS = pipm_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pipm_pkg::cmd_t                      cmd,
	output pipm_pkg::dp_status_t                status,
	input  logic                                first_vertex,
	input  logic signed [COORD_BITS-1:0]        vertex_x,
	input  logic signed [COORD_BITS-1:0]        vertex_y,
	input  logic signed [COORD_BITS-1:0]        query_x,
	input  logic signed [COORD_BITS-1:0]        query_y,
	input  logic [pipm_pkg::MARGIN_BITS-1:0]    margin,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                hit,
	output logic                                odd_crossings,
	output logic                                near_edge
);

	localparam int K = COORD_BITS + 1;
	localparam int L = (K > pipm_pkg::MARGIN_BITS) ? K : pipm_pkg::MARGIN_BITS;
	localparam int PW = 2 * L + 2;
	localparam int AW = 4 * L + 2;

	logic signed [COORD_BITS-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic signed [COORD_BITS-1:0] ax_q, ay_q, qx_q, qy_q;
	logic [pipm_pkg::MARGIN_BITS-1:0] mrg_q;
	logic parity_q, near_q;

	logic signed [COORD_BITS-1:0] ea_x, ea_y, eb_x, eb_y;
	logic signed [K-1:0] dx_q, dy_q, dx1_q, dy1_q, ex_q, ey_q;
	logic straddle_q, dy_neg_q;

	pipm_pkg::op_sel_t sel [2];
	logic signed [L:0] opv [2];

	logic signed [PW-1:0] prod_s1;
	pipm_pkg::acc_mode_t mode_s1;
	pipm_pkg::shift_t shift_s1;
	pipm_pkg::dest_t dest_s1;

	logic signed [AW-1:0] term_w, term_sh, base_w, acc_next, acc_q;
	logic signed [PW-1:0] d_q, len_q, rn_q, da_q, db_q, rr_q;
	logic [2*L-1:0] dmag_q;
	logic signed [PW-1:0] d_neg, rl_w;

	logic left_w, len_nz, perp_ok, rn_le0, rl_ge0, da_ok, db_ok, near_now;
	logic out_valid_q;

	assign ea_x = cmd.edge_close ? prev_x_q : ax_q;
	assign ea_y = cmd.edge_close ? prev_y_q : ay_q;
	assign eb_x = cmd.edge_close ? first_x_q : prev_x_q;
	assign eb_y = cmd.edge_close ? first_y_q : prev_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_x_q <= '0;
			first_y_q <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
			ax_q <= '0;
			ay_q <= '0;
			qx_q <= '0;
			qy_q <= '0;
			mrg_q <= '0;
			parity_q <= 1'b0;
			near_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				ax_q <= prev_x_q;
				ay_q <= prev_y_q;
				prev_x_q <= vertex_x;
				prev_y_q <= vertex_y;
				if (first_vertex) begin
					first_x_q <= vertex_x;
					first_y_q <= vertex_y;
					qx_q <= query_x;
					qy_q <= query_y;
					mrg_q <= margin;
					parity_q <= 1'b0;
					near_q <= 1'b0;
				end
			end else if (cmd.decide) begin
				parity_q <= parity_q ^ left_w;
				near_q <= near_q | near_now;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.edge_open || cmd.edge_close) begin
			dx_q <= K'(eb_x) - K'(ea_x);
			dy_q <= K'(eb_y) - K'(ea_y);
			dx1_q <= K'(ea_x) - K'(qx_q);
			dy1_q <= K'(ea_y) - K'(qy_q);
			ex_q <= K'(eb_x) - K'(qx_q);
			ey_q <= K'(eb_y) - K'(qy_q);
			straddle_q <= (ea_y <= qy_q && qy_q < eb_y) || (eb_y <= qy_q && qy_q < ea_y);
			dy_neg_q <= (eb_y < ea_y);
		end
	end

	assign sel[0] = cmd.uop.opa;
	assign sel[1] = cmd.uop.opb;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			unique case (sel[i])
				pipm_pkg::OP_DX:  opv[i] = (L+1)'(dx_q);
				pipm_pkg::OP_DY:  opv[i] = (L+1)'(dy_q);
				pipm_pkg::OP_DX1: opv[i] = (L+1)'(dx1_q);
				pipm_pkg::OP_DY1: opv[i] = (L+1)'(dy1_q);
				pipm_pkg::OP_EX:  opv[i] = (L+1)'(ex_q);
				pipm_pkg::OP_EY:  opv[i] = (L+1)'(ey_q);
				pipm_pkg::OP_MRG: opv[i] = $signed((L+1)'(mrg_q));
				pipm_pkg::OP_DH:  opv[i] = $signed({1'b0, dmag_q[2*L-1:L]});
				pipm_pkg::OP_DL:  opv[i] = $signed({1'b0, dmag_q[L-1:0]});
				pipm_pkg::OP_LH:  opv[i] = $signed({1'b0, len_q[2*L-1:L]});
				pipm_pkg::OP_LL:  opv[i] = $signed({1'b0, len_q[L-1:0]});
				pipm_pkg::OP_RH:  opv[i] = $signed({1'b0, rr_q[2*L-1:L]});
				pipm_pkg::OP_RL:  opv[i] = $signed({1'b0, rr_q[L-1:0]});
				default:          opv[i] = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_s1 <= pipm_pkg::ACC_NONE;
			dest_s1 <= pipm_pkg::DST_NONE;
		end else begin
			mode_s1 <= cmd.uop.mode;
			dest_s1 <= cmd.uop.dest;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= opv[0] * opv[1];
		shift_s1 <= cmd.uop.shift;
	end

	always_comb begin
		term_w = AW'(prod_s1);
		unique case (shift_s1)
			pipm_pkg::SH_0:  term_sh = term_w;
			pipm_pkg::SH_L:  term_sh = term_w <<< L;
			pipm_pkg::SH_L1: term_sh = term_w <<< (L + 1);
			pipm_pkg::SH_2L: term_sh = term_w <<< (2 * L);
		endcase
		base_w = (mode_s1 == pipm_pkg::ACC_START) ? '0 : acc_q;
		acc_next = (mode_s1 == pipm_pkg::ACC_SUB) ? base_w - term_sh : base_w + term_sh;
	end

	always_ff @(posedge clk) begin
		if (mode_s1 != pipm_pkg::ACC_NONE) begin
			acc_q <= acc_next;
			unique case (dest_s1)
				pipm_pkg::DST_NONE: ;
				pipm_pkg::DST_D:    d_q <= acc_next[PW-1:0];
				pipm_pkg::DST_LEN:  len_q <= acc_next[PW-1:0];
				pipm_pkg::DST_RN:   rn_q <= acc_next[PW-1:0];
				pipm_pkg::DST_DA:   da_q <= acc_next[PW-1:0];
				pipm_pkg::DST_DB:   db_q <= acc_next[PW-1:0];
				pipm_pkg::DST_RR:   rr_q <= acc_next[PW-1:0];
				default: ;
			endcase
		end
		dmag_q <= d_q[PW-1] ? d_neg[2*L-1:0] : d_q[2*L-1:0];
	end

	assign d_neg = -d_q;
	assign rl_w = rn_q + len_q;

	always_comb begin
		left_w = straddle_q && (dy_neg_q ? (!d_q[PW-1] && (d_q != '0)) : d_q[PW-1]);
		len_nz = (len_q != '0);
		perp_ok = acc_q[AW-1] || (acc_q == '0);
		rn_le0 = rn_q[PW-1] || (rn_q == '0);
		rl_ge0 = !rl_w[PW-1];
		da_ok = da_q[PW-1] || (da_q == '0);
		db_ok = db_q[PW-1] || (db_q == '0);
		near_now = len_nz && perp_ok &&
			((rn_le0 && rl_ge0) || (!rn_le0 && da_ok) || (!rl_ge0 && db_ok));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			hit <= parity_q | near_q;
			odd_crossings <= parity_q;
			near_edge <= near_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status.out_busy = out_valid_q && out_stall;

endmodule

// File: sv/point_in_polygon_with_margin.sv
// Point-in-polygon test with an edge margin, one polygon vertex per item.
// A vertex that is not marked first passes, from acceptance to the next
// acceptance, through edge set-up, 20 products through the one shared signed
// multiplier of at least COORD_BITS+2 bits, a drain of the accumulator and a
// decision. A vertex marked first and not last is only stored; a last vertex
// adds the closing edge and the result. The result register lets the next
// polygon start while a result waits to be taken.
module point_in_polygon_with_margin #(
	parameter int COORD_BITS = pipm_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                first_vertex,
	input  logic                                last_vertex,
	input  logic signed [COORD_BITS-1:0]        vertex_x,
	input  logic signed [COORD_BITS-1:0]        vertex_y,
	input  logic signed [COORD_BITS-1:0]        query_x,
	input  logic signed [COORD_BITS-1:0]        query_y,
	input  logic [pipm_pkg::MARGIN_BITS-1:0]    margin,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                hit,
	output logic                                odd_crossings,
	output logic                                near_edge
);

	pipm_pkg::cmd_t cmd;
	pipm_pkg::dp_status_t status;

	pipm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.first_vertex (first_vertex),
		.last_vertex  (last_vertex),
		.in_stall     (in_stall),
		.status       (status),
		.cmd          (cmd)
	);

	pipm_dp #(
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.first_vertex  (first_vertex),
		.vertex_x      (vertex_x),
		.vertex_y      (vertex_y),
		.query_x       (query_x),
		.query_y       (query_y),
		.margin        (margin),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.hit           (hit),
		.odd_crossings (odd_crossings),
		.near_edge     (near_edge)
	);

endmodule
